@@ rtl/gtg_pkg.sv @@
// shared types and constants of the go-to-goal steering pipeline
package gtg_pkg;

	localparam int XW            = 34;
	localparam int ZW            = 24;
	localparam int DW            = 20;
	localparam int EW            = 18;
	localparam int PRE_SHIFT     = 14;
	localparam int ATAN_ENTRIES  = 24;
	localparam int MAX_STAGES    = 24;

	localparam logic signed [ZW-1:0] HALF_PI_U20   = ZW'(1647099);
	localparam logic [29:0]          INV_GAIN_Q30  = 30'd652032874;
	localparam logic [DW-1:0]        DIST_MIN_Q10  = DW'(102);
	localparam logic [EW-1:0]        ANGLE_MAX_Q12 = EW'(819);
	localparam logic [EW-1:0]        OUT15_MAX     = EW'(32767);

	localparam logic [19:0] ATAN_U20 [ATAN_ENTRIES] = '{
		20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
		20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
		20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
		20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
	};

	typedef enum logic [1:0] {
		REG_TARGET_X    = 2'd0,
		REG_TARGET_Y    = 2'd1,
		REG_GAIN        = 2'd2,
		REG_SPEED_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [11:0]        gain;
		logic [14:0]        speed_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [15:0]   hd;
	} vec_t;

	typedef struct packed {
		logic [14:0] forward_speed;
		logic [14:0] turn_rate;
	} cmd_t;

endpackage

@@ rtl/go_to_goal_proportional_steer.sv @@
// top level of the go-to-goal proportional steering pipeline
// each pose is registered in the front stage, in every cordic stage and in every post stage on its way out
// throughput: one pose per cycle while the output is not stalled, set by one cordic micro-rotation per stage
// every stage holds under back-pressure and frees itself when empty
// reset clears all valid bits and loads the config registers with their defaults
module go_to_goal_proportional_steer #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // forward_speed[14:0], turn_rate[29:15], zero[31:30]
);

	gtg_pkg::cfg_t cfg_q;
	gtg_pkg::vec_t f_vec, c_vec;
	gtg_pkg::cmd_t cmd;
	logic          f_valid, f_ready, c_valid, c_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x    <= 16'sd1024;
			cfg_q.target_y    <= 16'sd1024;
			cfg_q.gain        <= 12'd256;
			cfg_q.speed_limit <= 15'd1024;
		end else if (cfg_valid) begin
			case (gtg_pkg::reg_idx_t'(cfg_index))
				gtg_pkg::REG_TARGET_X:    cfg_q.target_x    <= cfg_data;
				gtg_pkg::REG_TARGET_Y:    cfg_q.target_y    <= cfg_data;
				gtg_pkg::REG_GAIN:        cfg_q.gain        <= cfg_data[11:0];
				gtg_pkg::REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	gtg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pos_x     (s_tdata[15:0]),
		.pos_y     (s_tdata[31:16]),
		.heading   (s_tdata[47:32]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_vec   (f_vec)
	);

	gtg_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_vec    (f_vec),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_vec   (c_vec)
	);

	gtg_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_vec    (c_vec),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cmd   (cmd)
	);

	assign m_tdata = {2'b00, cmd.turn_rate, cmd.forward_speed};

endmodule

@@ rtl/gtg_front.sv @@
// difference to target and quadrant pre-rotation stage
module gtg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  gtg_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	output logic              out_valid,
	input  logic              out_ready,
	output gtg_pkg::vec_t     out_vec
);

	logic signed [16:0]          dx, dy;
	logic signed [gtg_pkg::XW-1:0] xe, ye;
	gtg_pkg::vec_t               nxt;
	gtg_pkg::vec_t               vec_s1;
	logic                        vld_s1;

	assign dx = {cfg.target_x[15], cfg.target_x} - {pos_x[15], pos_x};
	assign dy = {cfg.target_y[15], cfg.target_y} - {pos_y[15], pos_y};
	assign xe = {{(gtg_pkg::XW-17-gtg_pkg::PRE_SHIFT){dx[16]}}, dx,
		{gtg_pkg::PRE_SHIFT{1'b0}}};
	assign ye = {{(gtg_pkg::XW-17-gtg_pkg::PRE_SHIFT){dy[16]}}, dy,
		{gtg_pkg::PRE_SHIFT{1'b0}}};

	always_comb begin
		nxt.hd = heading;
		nxt.x  = xe;
		nxt.y  = ye;
		nxt.z  = '0;
		if (xe[gtg_pkg::XW-1]) begin
			if (!ye[gtg_pkg::XW-1]) begin
				nxt.x = ye;
				nxt.y = -xe;
				nxt.z = gtg_pkg::HALF_PI_U20;
			end else begin
				nxt.x = -ye;
				nxt.y = xe;
				nxt.z = -gtg_pkg::HALF_PI_U20;
			end
		end
	end

	assign in_ready = ~vld_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_vec   = vec_s1;

endmodule

@@ rtl/gtg_cordic.sv @@
// vectoring cordic, one micro-rotation per pipeline stage
module gtg_cordic #(
	parameter int STAGES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gtg_pkg::vec_t in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output gtg_pkg::vec_t out_vec
);

	gtg_pkg::vec_t vin   [STAGES];
	logic          vin_v [STAGES];
	gtg_pkg::vec_t vec_s [STAGES];
	logic          vld_s [STAGES];
	logic          rdy   [STAGES];

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			gtg_pkg::vec_t             nxt;
			logic signed [gtg_pkg::XW-1:0] xs, ys;
			logic signed [gtg_pkg::ZW-1:0] ang;

			if (i == 0) begin : g_first
				assign vin[i]   = in_vec;
				assign vin_v[i] = in_valid;
			end else begin : g_next
				assign vin[i]   = vec_s[i-1];
				assign vin_v[i] = vld_s[i-1];
			end

			if (i == STAGES - 1) begin : g_last
				assign rdy[i] = ~vld_s[i] | out_ready;
			end else begin : g_mid
				assign rdy[i] = ~vld_s[i] | rdy[i+1];
			end

			assign xs  = vin[i].x >>> i;
			assign ys  = vin[i].y >>> i;
			assign ang = gtg_pkg::ZW'(gtg_pkg::ATAN_U20[i]);

			always_comb begin
				nxt.hd = vin[i].hd;
				if (!vin[i].y[gtg_pkg::XW-1] && (vin[i].y != '0)) begin
					nxt.x = vin[i].x + ys;
					nxt.y = vin[i].y - xs;
					nxt.z = vin[i].z + ang;
				end else begin
					nxt.x = vin[i].x - ys;
					nxt.y = vin[i].y + xs;
					nxt.z = vin[i].z - ang;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (rdy[i]) begin
					vld_s[i] <= vin_v[i];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[i] && vin_v[i]) begin
					vec_s[i] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[STAGES-1];
	assign out_vec   = vec_s[STAGES-1];

endmodule

@@ rtl/gtg_post.sv @@
// distance scaling, heading error and command selection stages
module gtg_post (
	input  logic          clk,
	input  logic          arst_n,
	input  gtg_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  gtg_pkg::vec_t in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output gtg_pkg::cmd_t out_cmd
);

	localparam int XU = gtg_pkg::XW - 1;
	localparam int LW = 17;
	localparam int HW = XU - LW;

	logic en1, en2, en3, en4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1: clamp, split product, heading error
	logic [XU-1:0]              xc;
	logic [LW+29:0]             plo;
	logic [HW+29:0]             phi;
	logic signed [gtg_pkg::ZW:0] err;
	logic [gtg_pkg::ZW:0]       eabs;
	logic [gtg_pkg::ZW+1:0]     eround;
	logic [LW+29:0]             plo_s1;
	logic [HW+29:0]             phi_s1;
	logic [gtg_pkg::EW-1:0]     eabs_s1;

	assign xc   = in_vec.x[gtg_pkg::XW-1] ? '0 : in_vec.x[XU-1:0];
	assign plo  = (LW+30)'(xc[LW-1:0]) * (LW+30)'(gtg_pkg::INV_GAIN_Q30);
	assign phi  = (HW+30)'(xc[XU-1:LW]) * (HW+30)'(gtg_pkg::INV_GAIN_Q30);
	assign err  = {in_vec.z[gtg_pkg::ZW-1], in_vec.z}
		- {in_vec.hd[15], in_vec.hd, 8'h00};
	assign eabs = err[gtg_pkg::ZW] ? -err : err;
	assign eround = {1'b0, eabs} + (gtg_pkg::ZW+2)'(128);

	// stage 2: sum of partial products
	logic [63:0]            psum;
	logic [gtg_pkg::DW-1:0] dist_s2;
	logic [gtg_pkg::EW-1:0] eabs_s2;

	assign psum = ({(64-HW-30-LW)'(0), phi_s1, {LW{1'b0}}})
		+ 64'(plo_s1) + (64'd1 << 43);

	// stage 3: speed product and decisions
	logic [31:0]  prod_s3;
	logic         near_s3, turn_s3;
	logic [14:0]  tval_s3;

	// stage 4: rounding, limit and selection
	logic [32:0]  sround;
	logic [24:0]  spd;
	logic [14:0]  spd_lim;
	gtg_pkg::cmd_t cmd_nxt;
	gtg_pkg::cmd_t cmd_s4;

	assign sround  = {1'b0, prod_s3} + 33'd128;
	assign spd     = sround[32:8];
	assign spd_lim = (spd > 25'(cfg.speed_limit)) ? cfg.speed_limit : spd[14:0];

	always_comb begin
		cmd_nxt = '0;
		if (near_s3) begin
			if (turn_s3) begin
				cmd_nxt.turn_rate = tval_s3;
			end else begin
				cmd_nxt.forward_speed = spd_lim;
			end
		end
	end

	assign en4 = ~vld_s4 | out_ready;
	assign en3 = ~vld_s3 | en4;
	assign en2 = ~vld_s2 | en3;
	assign en1 = ~vld_s1 | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			plo_s1  <= plo;
			phi_s1  <= phi;
			eabs_s1 <= eround[gtg_pkg::ZW+1:8];
		end
		if (en2 && vld_s1) begin
			dist_s2 <= psum[63:44];
			eabs_s2 <= eabs_s1;
		end
		if (en3 && vld_s2) begin
			prod_s3 <= 32'(cfg.gain) * 32'(dist_s2);
			near_s3 <= dist_s2 > gtg_pkg::DIST_MIN_Q10;
			turn_s3 <= eabs_s2 > gtg_pkg::ANGLE_MAX_Q12;
			tval_s3 <= (eabs_s2 > gtg_pkg::OUT15_MAX) ? 15'h7FFF : eabs_s2[14:0];
		end
		if (en4 && vld_s3) begin
			cmd_s4 <= cmd_nxt;
		end
	end

	assign out_valid = vld_s4;
	assign out_cmd   = cmd_s4;

endmodule

@@ rtl/gtg_checker.sv @@
// port-level checks of the steering pipeline and their bind
module gtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed under stall");

	// never drive and turn at once
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] == 15'd0) || (m_tdata[29:15] == 15'd0))
		else $error("speed and turn rate both nonzero");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("padding bits set");

	// the input is ready whenever the output side is free and no pose is offered
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && m_tready && !s_tvalid && $past(!s_tvalid) |-> s_tready)
		else $error("input stalled while output side is free");

endmodule

bind go_to_goal_proportional_steer gtg_checker u_gtg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
// self-checking testbench of the go-to-goal steering pipeline: directed table, random poses
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES    = 16;
	localparam int LIMIT     = 200000;
	localparam int HOLD_LEN  = 100;
	localparam int TAIL_WAIT = STAGES + 15;

	typedef longint unsigned u64_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // pos_x[15:0], pos_y[31:16], heading[47:32]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // forward_speed[14:0], turn_rate[29:15], zero[31:30]

	typedef struct {
		bit                 is_cfg;
		gtg_pkg::reg_idx_t  idx;
		logic [15:0]        val;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
		bit                 typed;
		gtg_pkg::cmd_t      want;
	} row_t;

	logic signed [15:0] goal_x    = 16'sd1024;
	logic signed [15:0] goal_y    = 16'sd1024;
	logic [11:0]        gain_q8   = 12'd256;
	logic [14:0]        speed_max = 15'd1024;

	gtg_pkg::cmd_t pending_cmds[$];
	row_t plan[$];
	int   err_count   = 0;
	int   cycles      = 0;
	int   send_idle   = 15;
	int   recv_idle   = 83;
	bit   hold_req    = 1'b0;
	bit   hold_taken  = 1'b0;
	int   hold_left   = 0;

	go_to_goal_proportional_steer #(
		.CORDIC_STAGES(STAGES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic gtg_pkg::cmd_t steer_cmd(logic signed [15:0] px,
			logic signed [15:0] py, logic signed [15:0] hd);
		longint x, y, z, t, xs, ys, err;
		u64_t dist_q10, err_mag, speed;
		gtg_pkg::cmd_t c;
		x = (longint'(goal_x) - longint'(px)) * 16384;
		y = (longint'(goal_y) - longint'(py)) * 16384;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(gtg_pkg::HALF_PI_U20);
			end else begin
				x = -y;
				y = t;
				z = -longint'(gtg_pkg::HALF_PI_U20);
			end
		end
		for (int i = 0; i < STAGES && i < gtg_pkg::ATAN_ENTRIES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(gtg_pkg::ATAN_U20[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(gtg_pkg::ATAN_U20[i]);
			end
		end
		if (x < 0)
			x = 0;
		dist_q10 = (u64_t'(x) * u64_t'(gtg_pkg::INV_GAIN_Q30) + (64'd1 << 43)) >> 44;
		err = z - longint'(hd) * 256;
		err_mag = (err < 0) ? u64_t'(-err) : u64_t'(err);
		err_mag = (err_mag + 128) >> 8;
		c = '0;
		if (dist_q10 > u64_t'(gtg_pkg::DIST_MIN_Q10)) begin
			if (err_mag > u64_t'(gtg_pkg::ANGLE_MAX_Q12)) begin
				c.turn_rate = (err_mag > u64_t'(gtg_pkg::OUT15_MAX)) ? 15'h7fff
					: err_mag[14:0];
			end else begin
				speed = (u64_t'(gain_q8) * dist_q10 + 128) >> 8;
				if (speed > u64_t'(speed_max))
					speed = u64_t'(speed_max);
				c.forward_speed = speed[14:0];
			end
		end
		return c;
	endfunction

	function automatic void plan_cfg(gtg_pkg::reg_idx_t idx, logic [15:0] val);
		row_t r;
		r = '{idx: gtg_pkg::REG_TARGET_X, default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		plan.push_back(r);
	endfunction

	function automatic void plan_pose(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd, bit typed, logic [14:0] fs, logic [14:0] tr);
		row_t r;
		r = '{idx: gtg_pkg::REG_TARGET_X, default: '0};
		r.px = px;
		r.py = py;
		r.hd = hd;
		r.typed = typed;
		r.want.forward_speed = fs;
		r.want.turn_rate = tr;
		plan.push_back(r);
	endfunction

	task automatic write_reg(gtg_pkg::reg_idx_t idx, logic [15:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cmds.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			gtg_pkg::REG_TARGET_X:    goal_x    = val;
			gtg_pkg::REG_TARGET_Y:    goal_y    = val;
			gtg_pkg::REG_GAIN:        gain_q8   = val[11:0];
			gtg_pkg::REG_SPEED_LIMIT: speed_max = val[14:0];
			default: ;
		endcase
	endtask

	task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd, gtg_pkg::cmd_t want);
		while (int'($urandom_range(99)) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hd, py, px};
		pending_cmds.push_back(want);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic pick_pose(output logic signed [15:0] px, output logic signed [15:0] py,
			output logic signed [15:0] hd);
		int  mode, ox, oy;
		real b;
		mode = $urandom_range(99);
		if (mode < 40) begin
			// heading near the bearing so both drive and turn show up
			ox = int'($urandom_range(6000)) - 3000;
			oy = int'($urandom_range(6000)) - 3000;
			px = goal_x + 16'(ox);
			py = goal_y + 16'(oy);
			b = $atan2(real'(longint'(goal_y) - longint'(py)),
				real'(longint'(goal_x) - longint'(px)));
			hd = 16'($rtoi(b * 4096.0) + int'($urandom_range(2400)) - 1200);
		end else if (mode < 60) begin
			// around the stop radius
			ox = int'($urandom_range(300)) - 150;
			oy = int'($urandom_range(300)) - 150;
			px = goal_x + 16'(ox);
			py = goal_y + 16'(oy);
			hd = 16'($urandom);
		end else begin
			px = 16'($urandom);
			py = 16'($urandom);
			hd = 16'($urandom);
		end
	endtask

	task automatic run_phase(int n, int s_idle, int r_idle);
		logic signed [15:0] px, py, hd;
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (n) begin
			pick_pose(px, py, hd);
			send_pose(px, py, hd, steer_cmd(px, py, hd));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (int'($urandom_range(99)) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		gtg_pkg::cmd_t got;
		gtg_pkg::cmd_t want;
		if (m_tvalid && m_tready) begin
			got.forward_speed = m_tdata[14:0];
			got.turn_rate     = m_tdata[29:15];
			if (pending_cmds.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				err_count++;
			end else begin
				want = pending_cmds.pop_front();
				if (got.forward_speed !== want.forward_speed) begin
					$error("forward_speed expected %0d got %0d", want.forward_speed,
						got.forward_speed);
					err_count++;
				end
				if (got.turn_rate !== want.turn_rate) begin
					$error("turn_rate expected %0d got %0d", want.turn_rate, got.turn_rate);
					err_count++;
				end
			end
		end
	end

	initial begin
		// defaults after reset: goal (1.0, 1.0), gain 1.0, limit 1.0
		plan_pose(1024, 1024, 0, 1'b1, 15'd0, 15'd0);
		plan_pose(1074, 1024, 0, 1'b1, 15'd0, 15'd0);
		plan_pose(1024, 0, -32768, 1'b1, 15'd0, 15'h7fff);
		plan_pose(1024, 2048, 32767, 1'b1, 15'd0, 15'h7fff);
		plan_pose(0, 1024, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(0, 1024, 4096, 1'b0, 15'd0, 15'd0);
		plan_pose(2048, 1024, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(2048, 2048, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(921, 1024, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(922, 1024, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(-32768, -32768, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(32767, 32767, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(-32768, 32767, -32768, 1'b0, 15'd0, 15'd0);
		plan_pose(32767, -32768, 32767, 1'b0, 15'd0, 15'd0);
		plan_cfg(gtg_pkg::REG_TARGET_X, 16'h7fff);
		plan_cfg(gtg_pkg::REG_TARGET_Y, 16'h8000);
		plan_cfg(gtg_pkg::REG_GAIN, 16'h0fff);
		plan_cfg(gtg_pkg::REG_SPEED_LIMIT, 16'h7fff);
		plan_pose(-32768, 32767, -3217, 1'b0, 15'd0, 15'd0);
		plan_pose(0, -32768, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(32767, -32768, 0, 1'b1, 15'd0, 15'd0);
		plan_cfg(gtg_pkg::REG_GAIN, 16'h0000);
		plan_cfg(gtg_pkg::REG_SPEED_LIMIT, 16'h0000);
		plan_pose(0, -32768, 0, 1'b0, 15'd0, 15'd0);
		plan_pose(-32768, -32768, 32767, 1'b0, 15'd0, 15'd0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_pose(plan[i].px, plan[i].py, plan[i].hd,
					plan[i].typed ? plan[i].want
						: steer_cmd(plan[i].px, plan[i].py, plan[i].hd));
		end

		write_reg(gtg_pkg::REG_TARGET_X, 16'($urandom));
		write_reg(gtg_pkg::REG_TARGET_Y, 16'($urandom));
		write_reg(gtg_pkg::REG_GAIN, 16'($urandom_range(4095)));
		write_reg(gtg_pkg::REG_SPEED_LIMIT, 16'($urandom_range(32767)));
		run_phase(180, 15, 83);

		write_reg(gtg_pkg::REG_TARGET_X, 16'h8000);
		write_reg(gtg_pkg::REG_TARGET_Y, 16'h7fff);
		write_reg(gtg_pkg::REG_GAIN, 16'h0fff);
		write_reg(gtg_pkg::REG_SPEED_LIMIT, 16'($urandom_range(2048)));
		run_phase(180, 83, 15);

		write_reg(gtg_pkg::REG_TARGET_X, 16'($urandom_range(8192)) - 16'd4096);
		write_reg(gtg_pkg::REG_TARGET_Y, 16'($urandom_range(8192)) - 16'd4096);
		write_reg(gtg_pkg::REG_GAIN, 16'($urandom_range(1024)));
		write_reg(gtg_pkg::REG_SPEED_LIMIT, 16'($urandom_range(32767)));
		// long receiver hold-off while poses keep coming, so the pipe fills and stalls
		hold_req <= 1'b1;
		run_phase(190, 0, 0);

		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gtg_pkg.sv
rtl/gtg_front.sv
rtl/gtg_cordic.sv
rtl/gtg_post.sv
rtl/go_to_goal_proportional_steer.sv
rtl/gtg_checker.sv
dv/tb_top.sv
